// ===== rtl/keyframe_track_sampler_macros.svh =====
// ----------------------------------------------------------------------------
// Keyframe track sampler assertion macros
// Shared property shorthands clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef KEYFRAME_TRACK_SAMPLER_MACROS_SVH
`define KEYFRAME_TRACK_SAMPLER_MACROS_SVH

// same-cycle implication
`define KFS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define KFS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/kfs_pkg.sv =====
// ----------------------------------------------------------------------------
// Keyframe track sampler package
// Sizes, command type and control codes shared by the sampler modules.
// ----------------------------------------------------------------------------
package kfs_pkg;

  localparam int MaxKeys    = 16;
  localparam int Components = 4;
  localparam int IdxW       = (MaxKeys > 1) ? $clog2(MaxKeys) : 1;
  localparam int CntW       = $clog2(MaxKeys + 1);
  localparam int CompW      = $clog2(Components);
  localparam int SpanMin    = 7;
  localparam int OneQ16     = 65536;
  localparam int DivSteps   = 48;
  localparam int StepW      = $clog2(DivSteps);
  localparam int FifoDepth  = 2;
  localparam int FifoPtrW   = $clog2(FifoDepth);
  localparam int FifoCntW   = $clog2(FifoDepth + 1);

  typedef enum logic {
    KIND_WRITE  = 1'b0,
    KIND_SAMPLE = 1'b1
  } kind_e;

  typedef struct packed {
    logic                        sample;
    logic                        wr_ok;
    logic [IdxW-1:0]             idx;
    logic [31:0]                 key_time;
    logic [Components-1:0][31:0] vals;
    logic [31:0]                 query;
    logic [CntW-1:0]             n;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RD_ONE,
    ST_CAP_ONE,
    ST_RD_LO,
    ST_RD_HI,
    ST_CAP_HI,
    ST_DIV,
    ST_FAC,
    ST_MUL,
    ST_ADD,
    ST_DONE
  } back_state_e;

endpackage

// ===== rtl/kfs_if.sv =====
// ----------------------------------------------------------------------------
// Keyframe track sampler channels
// Valid/ready input and result channels with their payload.
// ----------------------------------------------------------------------------
interface kfs_in_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [3:0]         key_index;
  logic signed [31:0] key_time;
  logic signed [31:0] value_x;
  logic signed [31:0] value_y;
  logic signed [31:0] value_z;
  logic signed [31:0] value_w;
  logic signed [31:0] query_time;

  modport source (output valid, kind, key_index, key_time, value_x, value_y, value_z,
                  value_w, query_time, input ready);
  modport sink   (input valid, kind, key_index, key_time, value_x, value_y, value_z,
                  value_w, query_time, output ready);
endinterface

interface kfs_out_if;
  logic               valid;
  logic               ready;
  logic               found;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic signed [31:0] out_w;

  modport source (output valid, found, out_x, out_y, out_z, out_w, input ready);
  modport sink   (input valid, found, out_x, out_y, out_z, out_w, output ready);
endinterface

// ===== rtl/kfs_front.sv =====
// ----------------------------------------------------------------------------
// Keyframe track sampler front end
// Accepts transactions, classifies them into commands and pushes the queue.
// ----------------------------------------------------------------------------
module kfs_front import kfs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  kfs_in_if.sink     in_i,
  input  logic [4:0] key_count_i,
  input  fifo_stat_t fifo_stat_i,
  output logic       push_o,
  output cmd_t       cmd_o
);

  logic vld_q, vld_d;
  cmd_t cmd_q, cmd_d;
  logic accept;
  logic [3:0][31:0] src;

  assign push_o     = vld_q && !fifo_stat_i.full;
  assign in_i.ready = !vld_q || push_o;
  assign accept     = in_i.valid && in_i.ready;
  assign cmd_o      = cmd_q;
  assign src        = {in_i.value_w, in_i.value_z, in_i.value_y, in_i.value_x};

  always_comb begin
    cmd_d          = cmd_q;
    cmd_d.sample   = (in_i.kind == KIND_SAMPLE);
    cmd_d.wr_ok    = (int'(in_i.key_index) < MaxKeys);
    cmd_d.idx      = IdxW'(in_i.key_index);
    cmd_d.key_time = in_i.key_time;
    for (int c = 0; c < Components; c++) begin
      cmd_d.vals[c] = src[c];
    end
    cmd_d.query    = in_i.query_time;
    cmd_d.n        = (int'(key_count_i) > MaxKeys) ? CntW'(MaxKeys) : CntW'(key_count_i);
    vld_d          = accept ? 1'b1 : (push_o ? 1'b0 : vld_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_d;
    end
  end

endmodule

// ===== rtl/kfs_fifo.sv =====
// ----------------------------------------------------------------------------
// Keyframe track sampler command queue
// Short queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module kfs_fifo import kfs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  cmd_t       push_data_i,
  input  logic       pop_i,
  output cmd_t       pop_data_o,
  output fifo_stat_t stat_o
);

  cmd_t                entry_q [FifoDepth];
  logic [FifoPtrW-1:0] wp_q, rp_q;
  logic [FifoCntW-1:0] cnt_q;

  assign stat_o.full  = (int'(cnt_q) == FifoDepth);
  assign stat_o.empty = (cnt_q == '0);
  assign pop_data_o   = entry_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wp_q <= (int'(wp_q) == FifoDepth - 1) ? '0 : wp_q + 1'b1;
      end
      if (pop_i) begin
        rp_q <= (int'(rp_q) == FifoDepth - 1) ? '0 : rp_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wp_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/kfs_back.sv =====
// ----------------------------------------------------------------------------
// Keyframe track sampler back end
// Key table, bracket scan, serial divider and per-component interpolation.
// ----------------------------------------------------------------------------
module kfs_back import kfs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cmd_t       cmd_i,
  input  fifo_stat_t fifo_stat_i,
  output logic       pop_o,
  kfs_out_if.source  out_o
);

  back_state_e state_q, state_d;

  logic [31:0]                 time_mem [MaxKeys];
  logic [Components-1:0][31:0] val_mem  [MaxKeys];
  logic signed [31:0]          t_rd_q;
  logic [Components-1:0][31:0] v_rd_q;
  logic [IdxW-1:0]             t_raddr, v_raddr;
  logic                        mem_we;

  logic [CntW-1:0]    issue_q, n_q;
  logic               rvld_q;
  logic               have_lo_q, have_hi_q;
  logic [IdxW-1:0]    lo_q, hi_q;
  logic signed [31:0] tlo_q, thi_q, q_q;
  logic               scan_more, scan_end;

  logic [Components-1:0][31:0] a_q, b_q;
  logic [31:0]        span_q;
  logic [47:0]        num_q, quo_q;
  logic [32:0]        rem_q;
  logic [StepW-1:0]   step_q;
  logic [16:0]        fac_q;
  logic [CompW-1:0]   comp_q;
  logic signed [50:0] prod_q;

  logic [3:0][31:0]   res_q;
  logic               found_q;
  logic               ovld_q;
  logic               out_free;

  logic signed [32:0] span_w, qdiff_w, cdiff_w;
  logic [32:0]        rem_sh;
  logic               qbit;

  assign scan_more = (issue_q < n_q);
  assign scan_end  = !scan_more && !rvld_q;
  assign out_free  = !ovld_q || out_o.ready;

  assign span_w  = {thi_q[31], thi_q} - {tlo_q[31], tlo_q};
  assign qdiff_w = {q_q[31], q_q} - {tlo_q[31], tlo_q};
  assign rem_sh  = {rem_q[31:0], num_q[47]};
  assign qbit    = (rem_sh >= {1'b0, span_q});
  assign cdiff_w = {b_q[comp_q][31], b_q[comp_q]} - {a_q[comp_q][31], a_q[comp_q]};

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (!fifo_stat_i.empty && cmd_i.sample) begin
          state_d = (cmd_i.n == '0) ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          state_d = (have_lo_q && have_hi_q) ? ST_RD_LO : ST_RD_ONE;
        end
      end
      ST_RD_ONE:  state_d = ST_CAP_ONE;
      ST_CAP_ONE: state_d = ST_DONE;
      ST_RD_LO:   state_d = ST_RD_HI;
      ST_RD_HI:   state_d = ST_CAP_HI;
      ST_CAP_HI:  state_d = ST_DIV;
      ST_DIV:     state_d = (int'(step_q) == DivSteps - 1) ? ST_FAC : ST_DIV;
      ST_FAC:     state_d = ST_MUL;
      ST_MUL:     state_d = ST_ADD;
      ST_ADD:     state_d = (int'(comp_q) == Components - 1) ? ST_DONE : ST_MUL;
      ST_DONE:    state_d = out_free ? ST_IDLE : ST_DONE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop_o   = 1'b0;
    mem_we  = 1'b0;
    t_raddr = issue_q[IdxW-1:0];
    v_raddr = lo_q;
    unique case (state_q)
      ST_IDLE: begin
        pop_o  = !fifo_stat_i.empty;
        mem_we = !fifo_stat_i.empty && !cmd_i.sample && cmd_i.wr_ok;
      end
      ST_RD_ONE: v_raddr = have_lo_q ? lo_q : hi_q;
      ST_RD_HI:  v_raddr = hi_q;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_DONE && out_free) begin
        ovld_q <= 1'b1;
      end else if (out_o.ready) begin
        ovld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      time_mem[cmd_i.idx] <= cmd_i.key_time;
      val_mem[cmd_i.idx]  <= cmd_i.vals;
    end
    t_rd_q <= time_mem[t_raddr];
    v_rd_q <= val_mem[v_raddr];
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        res_q     <= '0;
        found_q   <= 1'b0;
        q_q       <= cmd_i.query;
        n_q       <= cmd_i.n;
        issue_q   <= '0;
        rvld_q    <= 1'b0;
        have_lo_q <= 1'b0;
        have_hi_q <= 1'b0;
      end
      ST_SCAN: begin
        rvld_q <= scan_more;
        if (scan_more) begin
          issue_q <= issue_q + 1'b1;
        end
        if (rvld_q) begin
          if (t_rd_q <= q_q && (!have_lo_q || t_rd_q > tlo_q)) begin
            lo_q      <= issue_q[IdxW-1:0] - 1'b1;
            tlo_q     <= t_rd_q;
            have_lo_q <= 1'b1;
          end
          if (t_rd_q >= q_q && (!have_hi_q || t_rd_q < thi_q)) begin
            hi_q      <= issue_q[IdxW-1:0] - 1'b1;
            thi_q     <= t_rd_q;
            have_hi_q <= 1'b1;
          end
        end
        span_q <= (span_w < 33'(SpanMin)) ? 32'(SpanMin) : span_w[31:0];
        num_q  <= {qdiff_w[31:0], 16'h0000};
        rem_q  <= '0;
        quo_q  <= '0;
        step_q <= '0;
      end
      ST_CAP_ONE: begin
        for (int c = 0; c < Components; c++) begin
          res_q[c] <= v_rd_q[c];
        end
        found_q <= 1'b1;
      end
      ST_RD_HI:  a_q <= v_rd_q;
      ST_CAP_HI: b_q <= v_rd_q;
      ST_DIV: begin
        rem_q  <= qbit ? (rem_sh - {1'b0, span_q}) : rem_sh;
        quo_q  <= {quo_q[46:0], qbit};
        num_q  <= {num_q[46:0], 1'b0};
        step_q <= step_q + 1'b1;
      end
      ST_FAC: begin
        fac_q  <= (quo_q > 48'(OneQ16)) ? 17'(OneQ16) : quo_q[16:0];
        comp_q <= '0;
      end
      ST_MUL: prod_q <= 51'(cdiff_w * $signed({1'b0, fac_q}));
      ST_ADD: begin
        res_q[comp_q] <= a_q[comp_q] + prod_q[47:16];
        comp_q        <= comp_q + 1'b1;
        found_q       <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  logic        obuf_found_q;
  logic [3:0][31:0] obuf_q;

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && out_free) begin
      obuf_found_q <= found_q;
      obuf_q       <= res_q;
    end
  end

  assign out_o.valid = ovld_q;
  assign out_o.found = obuf_found_q;
  assign out_o.out_x = obuf_q[0];
  assign out_o.out_y = obuf_q[1];
  assign out_o.out_z = obuf_q[2];
  assign out_o.out_w = obuf_q[3];

endmodule

// ===== rtl/keyframe_track_sampler.sv =====
// A write passes the front-end command register and the queue, then the back
// end writes it to the key table while idle. A sample of no keys skips the
// scan. The back end takes one sample at a time, using the one-bit-a-cycle
// 48-step divider and one-component-a-step multiplier; the queue still takes
// commands. Reset clears control state only; the key table is undefined.
// ----------------------------------------------------------------------------
// Keyframe track sampler
// Keyframe table with bracketing scan and linear interpolation in Q16.16.
// ----------------------------------------------------------------------------
`include "keyframe_track_sampler_macros.svh"

module keyframe_track_sampler import kfs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  kfs_in_if.sink     in_i,
  kfs_out_if.source  out_o,
  input  logic       cfg_we_i,
  input  logic [4:0] cfg_data_i
);

  logic [4:0] key_count_q;
  logic       push, pop;
  cmd_t       push_cmd, pop_cmd;
  fifo_stat_t fifo_stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_count_q <= '0;
    end else if (cfg_we_i) begin
      key_count_q <= cfg_data_i;
    end
  end

  kfs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .key_count_i (key_count_q),
    .fifo_stat_i (fifo_stat),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  kfs_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .pop_i       (pop),
    .pop_data_o  (pop_cmd),
    .stat_o      (fifo_stat)
  );

  kfs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (pop_cmd),
    .fifo_stat_i (fifo_stat),
    .pop_o       (pop),
    .out_o       (out_o)
  );

  `KFS_ASSERT_IMPL(a_no_overflow, push && fifo_stat.full, 1'b0, "queue push while full")
  `KFS_ASSERT_IMPL(a_no_underflow, pop, !fifo_stat.empty, "queue pop while empty")
  `KFS_ASSERT_IMPL(a_empty_zero, out_o.valid && !out_o.found, out_o.out_x == 0 && out_o.out_y == 0 && out_o.out_z == 0 && out_o.out_w == 0, "nonzero result with nothing found")

endmodule

// ===== dv/kfs_sample_checker.sv =====
// ----------------------------------------------------------------------------
// Keyframe track sampler checker
// Watches the key and sample channels, keeps its own key table and key count,
// predicts each sampled vector and compares it with the block's result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module kfs_sample_checker import kfs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  kfs_in_if          in_m,
  kfs_out_if         out_m,
  input  logic       cfg_we_i,
  input  logic [4:0] cfg_data_i,
  output int         err_o,
  output int         pending_o,
  output int         results_o
);

  typedef struct packed {
    logic        found;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] w;
  } sample_res_t;

  logic signed [31:0] key_time_tab [MaxKeys];
  logic signed [31:0] key_val_tab  [MaxKeys][4];
  logic [4:0]         track_len;
  sample_res_t        sample_q [$];
  int                 mismatches;
  int                 results_seen;

  assign err_o     = mismatches;
  assign pending_o = sample_q.size();
  assign results_o = results_seen;

  function automatic sample_res_t predict_sample(logic signed [31:0] q);
    sample_res_t r;
    int          n;
    int          lo;
    int          hi;
    bit          have_lo;
    bit          have_hi;
    longint      span;
    longint      fac;
    longint      a;
    longint      d;
    int          k;
    r = '0;
    lo = 0;
    hi = 0;
    have_lo = 0;
    have_hi = 0;
    n = (track_len > MaxKeys) ? MaxKeys : int'(track_len);
    if (n == 0) return r;
    for (int i = 0; i < n; i++) begin
      if (key_time_tab[i] <= q && (!have_lo || key_time_tab[i] > key_time_tab[lo])) begin
        lo = i;
        have_lo = 1;
      end
      if (key_time_tab[i] >= q && (!have_hi || key_time_tab[i] < key_time_tab[hi])) begin
        hi = i;
        have_hi = 1;
      end
    end
    r.found = 1'b1;
    if (!have_lo || !have_hi) begin
      k = have_lo ? lo : hi;
      r.x = key_val_tab[k][0];
      r.y = key_val_tab[k][1];
      r.z = key_val_tab[k][2];
      r.w = key_val_tab[k][3];
      return r;
    end
    span = longint'(key_time_tab[hi]) - longint'(key_time_tab[lo]);
    if (span < SpanMin) span = SpanMin;
    fac = ((longint'(q) - longint'(key_time_tab[lo])) <<< 16) / span;
    if (fac > OneQ16) fac = OneQ16;
    for (int c = 0; c < 4; c++) begin
      a = longint'(key_val_tab[lo][c]);
      d = (longint'(key_val_tab[hi][c]) - a) * fac;
      a = a + (d >>> 16);
      case (c)
        0: r.x = a[31:0];
        1: r.y = a[31:0];
        2: r.z = a[31:0];
        default: r.w = a[31:0];
      endcase
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    sample_res_t exp_r;
    sample_res_t got_r;
    if (!rst_ni) begin
      track_len    <= '0;
      mismatches   = 0;
      results_seen = 0;
      sample_q.delete();
    end else begin
      if (cfg_we_i) track_len <= cfg_data_i;
      if (in_m.valid && in_m.ready) begin
        if (kind_e'(in_m.kind) == KIND_WRITE) begin
          key_time_tab[in_m.key_index]    <= in_m.key_time;
          key_val_tab[in_m.key_index][0]  <= in_m.value_x;
          key_val_tab[in_m.key_index][1]  <= in_m.value_y;
          key_val_tab[in_m.key_index][2]  <= in_m.value_z;
          key_val_tab[in_m.key_index][3]  <= in_m.value_w;
        end else begin
          sample_q = {sample_q, predict_sample(in_m.query_time)};
        end
      end
      if (out_m.valid && out_m.ready) begin
        results_seen++;
        got_r = {out_m.found, out_m.out_x, out_m.out_y, out_m.out_z, out_m.out_w};
        if (sample_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", got_r);
        end else begin
          exp_r = sample_q.pop_front();
          if (got_r !== exp_r) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected found=%0d %h %h %h %h got found=%0d %h %h %h %h",
                       exp_r.found, exp_r.x, exp_r.y, exp_r.z, exp_r.w,
                       got_r.found, got_r.x, got_r.y, got_r.z, got_r.w);
          end
        end
      end
    end
  end

endmodule

// ===== dv/tb_keyframe_track_sampler.sv =====
// ----------------------------------------------------------------------------
// Keyframe track sampler testbench
// Fills the key table, runs directed and random key writes and samples under
// several key counts with bursty input and a stalling result side.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_keyframe_track_sampler import kfs_pkg::*;;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we;
  logic [4:0] cfg_data;
  int         err_cnt;
  int         pending;
  int         results;
  int         burst_left;
  int         sample_cnt;
  int         write_cnt;
  int         hold_cnt;
  bit         held;
  int         rx_mode;
  int         rx_win;
  logic signed [31:0] shadow_time [MaxKeys];

  kfs_in_if  in_ch ();
  kfs_out_if out_ch ();

  keyframe_track_sampler dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data)
  );

  kfs_sample_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_m       (in_ch),
    .out_m      (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data),
    .err_o      (err_cnt),
    .pending_o  (pending),
    .results_o  (results)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

  // result side: random stall pattern plus one long hold-off
  initial begin
    out_ch.ready = 1'b0;
    hold_cnt = 0;
    held = 0;
    rx_mode = 0;
    rx_win = 0;
  end

  always @(posedge clk_i) begin
    if (rx_win == 0) begin
      rx_mode <= $urandom_range(0, 2);
      rx_win  <= $urandom_range(8, 64);
    end else begin
      rx_win <= rx_win - 1;
    end
    if (!held && results >= 60) begin
      held     <= 1;
      hold_cnt <= 500;
      out_ch.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ch.ready <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= $urandom_range(0, 1);
        default: out_ch.ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  task automatic send_txn(kind_e k, logic [3:0] idx, logic [31:0] t,
                          logic [31:0] vx, logic [31:0] vy, logic [31:0] vz,
                          logic [31:0] vw, logic [31:0] q);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 10);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_ch.valid      <= 1'b1;
    in_ch.kind       <= k;
    in_ch.key_index  <= idx;
    in_ch.key_time   <= t;
    in_ch.value_x    <= vx;
    in_ch.value_y    <= vy;
    in_ch.value_z    <= vz;
    in_ch.value_w    <= vw;
    in_ch.query_time <= q;
    do @(posedge clk_i); while (!in_ch.ready);
    if (k == KIND_WRITE) begin
      shadow_time[idx] = t;
      write_cnt++;
    end else begin
      sample_cnt++;
    end
  endtask

  task automatic write_key(logic [3:0] idx, logic [31:0] t);
    send_txn(KIND_WRITE, idx, t, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic sample_at(logic [31:0] q);
    send_txn(KIND_SAMPLE, 4'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom, q);
  endtask

  task automatic set_track_len(logic [4:0] n);
    in_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_data <= n;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  function automatic logic [31:0] pick_query();
    int          s;
    logic [31:0] q;
    s = $urandom_range(0, 9);
    q = shadow_time[$urandom_range(0, MaxKeys - 1)];
    if (s < 5) q = q + $urandom_range(0, 8) - 4 + ($urandom_range(0, 1) ? $urandom_range(0, 1 << 17) : 0);
    else if (s == 5) q = $urandom;
    else if (s == 6) q = 32'h8000_0000;
    else if (s == 7) q = 32'h7FFF_FFFF;
    return q;
  endfunction

  function automatic logic [31:0] pick_key_time();
    int s;
    s = $urandom_range(0, 9);
    if (s < 6) return $urandom_range(0, 1 << 20) - (1 << 19);
    if (s == 6) return shadow_time[$urandom_range(0, MaxKeys - 1)] + $urandom_range(0, 6);
    if (s == 7) return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    return $urandom;
  endfunction

  initial begin
    logic [4:0] lens [8];
    int         steps;
    lens = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd5, 5'd17, 5'd16, 5'd9};
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.kind = 1'b0;
    in_ch.key_index = '0;
    in_ch.key_time = '0;
    in_ch.value_x = '0;
    in_ch.value_y = '0;
    in_ch.value_z = '0;
    in_ch.value_w = '0;
    in_ch.query_time = '0;
    burst_left = 0;
    sample_cnt = 0;
    write_cnt = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty track, then fill every slot
    set_track_len(5'd0);
    sample_at(32'h0001_0000);
    send_txn(KIND_WRITE, 4'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
             32'h0, 32'hFFFF_FFFF, 32'h0);
    for (int i = 1; i < MaxKeys - 1; i++) write_key(4'(i), 32'((i - 4) * 32'h0001_0000));
    write_key(4'd7, 32'h0002_0000);
    write_key(4'd9, 32'h0004_0003);
    send_txn(KIND_WRITE, 4'd15, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
             32'hFFFF_FFFF, 32'h0, 32'h0);
    set_track_len(5'd16);
    sample_at(32'h8000_0000);
    sample_at(32'h7FFF_FFFF);
    sample_at(32'h0002_0000);
    sample_at(32'h0004_0001);
    sample_at(32'h0000_8000);
    sample_at(32'h0000_0000);

    for (int p = 0; p < 8; p++) begin
      set_track_len(p == 7 ? 5'($urandom_range(1, 31)) : lens[p]);
      steps = (lens[p] == 0) ? 15 : 55;
      for (int j = 0; j < steps; j++) begin
        if ($urandom_range(0, 9) < 7) sample_at(pick_query());
        else write_key(4'($urandom), pick_key_time());
      end
    end

    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    $display("Ran %0d key writes and %0d samples under eight key counts,", write_cnt, sample_cnt);
    $display("with bursty input, result stalls and one long hold-off; %0d results.", results);
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
